/* design/assert_macros.svh */
// assertion macros used by the checker file
// assumes clk_i and rst_ni are visible where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SBPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same, written as antecedent and consequent
`define SBPE_ASSERT_IMP(label, ante, cons, msg) \
  `SBPE_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* design/sbpe_pkg.sv */
// shared types and constants of the six-bit packing encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbpe_pkg;

  localparam logic [15:0] DEFAULT_KEY      = 16'h6501;
  localparam logic [15:0] DEFAULT_CAPACITY = 16'd8192;
  localparam logic [6:0]  CHAR_OFFSET      = 7'h3c;
  localparam logic [7:0]  POS_OFFSET       = 8'd13;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP = 1'b1;

  // output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] cap;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  code_char;
    logic        message_end;
    logic [15:0] emitted_count;
  } out_item_t;

  // up to two characters per request, slot 1 only valid with slot 0
  typedef struct packed {
    logic [1:0]      vld;
    out_item_t [1:0] item;
  } res_pair_t;

endpackage

`default_nettype wire

/* design/sbpe_pack.sv */
// message state and byte packing logic of the six-bit packing encoder
// depends on sbpe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbpe_pack import sbpe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      take_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      last_byte_i,
  output res_pair_t      res_o
);

  logic [6:0]  pos_q, pos_d;
  logic [5:0]  pend_q, pend_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] oc_q, oc_d;

  logic        active, room2, full;
  logic [7:0]  whiten, pos_mask, b;
  logic [5:0]  made, rest;
  logic [15:0] cnt1, cnt2;

  always_comb begin
    active   = oc_q < cfg_i.cap;
    room2    = ({1'b0, oc_q} + 17'd1) < {1'b0, cfg_i.cap};
    whiten   = cfg_i.key[15:8] + cfg_i.key[7:0];
    pos_mask = {pos_q, 1'b0} + POS_OFFSET;
    b        = data_byte_i ^ pos_mask ^ whiten;
    // phase 3 never occurs, treated as phase 2
    full     = phase_q[1];
    case (phase_q)
      2'd0: begin
        made = b[7:2];
        rest = {b[1:0], 4'b0000};
      end
      2'd1: begin
        made = pend_q | {2'b00, b[7:4]};
        rest = {b[3:0], 2'b00};
      end
      default: begin
        made = pend_q | {4'b0000, b[7:6]};
        rest = b[5:0];
      end
    endcase
    cnt1 = oc_q + 16'd1;
    cnt2 = oc_q + 16'd2;

    // second slot is either the group's last code or the flush code
    res_o.vld[0] = active;
    res_o.vld[1] = active && room2 && (full || last_byte_i);
    res_o.item[0].code_char     = {1'b0, made} + CHAR_OFFSET;
    res_o.item[0].message_end   = last_byte_i && !res_o.vld[1];
    res_o.item[0].emitted_count = cnt1;
    res_o.item[1].code_char     = {1'b0, rest} + CHAR_OFFSET;
    res_o.item[1].message_end   = last_byte_i;
    res_o.item[1].emitted_count = cnt2;

    pos_d   = pos_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    oc_d    = oc_q;
    if (take_i) begin
      if (last_byte_i) begin
        pos_d   = '0;
        pend_d  = '0;
        phase_d = '0;
        oc_d    = '0;
      end else if (active) begin
        pos_d = pos_q + 7'd1;
        if (full) begin
          pend_d  = '0;
          phase_d = '0;
          oc_d    = room2 ? cnt2 : cnt1;
        end else begin
          pend_d  = rest;
          phase_d = phase_q + 2'd1;
          oc_d    = cnt1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pend_q  <= '0;
      phase_q <= '0;
      oc_q    <= '0;
    end else begin
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      oc_q    <= oc_d;
    end
  end

endmodule

`default_nettype wire

/* design/six_bit_packing_encoder.sv */
// Six-bit packing encoder, top level.
// Input channel: in_valid_i/in_ready_o carry one message byte per request with
// last_byte_i marking the end of the message. Output channel: out_valid_o/
// out_ready_i carry one code character per request with its running count and
// message_end_o on the final character of the message.
// Configuration: cfg_we_i writes cfg_data_i to the register cfg_idx_i (key,
// capacity) in the same cycle; write only while no request is in flight.
// Queue: the characters of a byte are written into the output queue when it is taken.
// Throughput: a byte may be taken every cycle while at least two of the four
// output queue slots are free; a byte yields one or two characters and the
// output drains one per cycle while out_ready_i is high, so the sustained rate
// is set by the output port.
// Stall: when out_ready_i is low the queue holds its head steady and in_ready_o
// drops once fewer than two slots are free.
// Reset: key and capacity return to their defaults, the message state and the
// output queue are cleared; no characters are pending.
// depends on sbpe_pkg and sbpe_pack
`timescale 1ns / 1ps
`default_nettype none

module six_bit_packing_encoder import sbpe_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 last_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [6:0]                code_char_o,
  output logic                      message_end_o,
  output logic [15:0]               emitted_count_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);

  cfg_t      cfg_q;
  res_pair_t res;
  logic      take, pop;

  out_item_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_nx, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic [1:0]               n_wr;
  out_item_t                head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key <= DEFAULT_KEY;
      cfg_q.cap <= DEFAULT_CAPACITY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_KEY: cfg_q.key <= cfg_data_i;
        CFG_IDX_CAP: cfg_q.cap <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbpe_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (res)
  );

  // output queue, room for the two characters a byte can make
  assign in_ready_o  = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    if (!take)           n_wr = 2'd0;
    else if (res.vld[1]) n_wr = 2'd2;
    else if (res.vld[0]) n_wr = 2'd1;
    else                 n_wr = 2'd0;
    wr_ptr_nx = wr_ptr_q + FIFO_PTR_W'(1);
    wr_ptr_d  = wr_ptr_q + FIFO_PTR_W'(n_wr);
    rd_ptr_d  = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d     = cnt_q + FIFO_CNT_W'(n_wr) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.vld[0]) begin
      mem_q[wr_ptr_q] <= res.item[0];
    end
    if (take && res.vld[1]) begin
      mem_q[wr_ptr_nx] <= res.item[1];
    end
  end

  assign head            = mem_q[rd_ptr_q];
  assign code_char_o     = head.code_char;
  assign message_end_o   = head.message_end;
  assign emitted_count_o = head.emitted_count;

endmodule

`default_nettype wire

/* design/sbpe_checker.sv */
// port-level checks of the six-bit packing encoder, bound to the top level
// depends on assert_macros.svh and sbpe_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbpe_checker import sbpe_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [7:0]           data_byte_i,
  input wire logic                 last_byte_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [6:0]           code_char_o,
  input wire logic                 message_end_o,
  input wire logic [15:0]          emitted_count_o,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [15:0]          cfg_data_i
);

  // stalled output request holds
  `SBPE_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 (out_valid_o && $stable(code_char_o) && $stable(message_end_o) && $stable(emitted_count_o)), "output changed under stall")
  // code plus offset stays printable
  `SBPE_ASSERT_IMP(a_char_range, out_valid_o, code_char_o >= 7'd60 && code_char_o <= 7'd123, "code char out of range")
  // counts start at one within a message
  `SBPE_ASSERT_IMP(a_count_nz, out_valid_o, emitted_count_o != 16'd0, "emitted count is zero")
  // empty queue always has room
  `SBPE_ASSERT_IMP(a_empty_ready, !out_valid_o, in_ready_o, "not ready with empty output")

endmodule

bind six_bit_packing_encoder sbpe_checker u_sbpe_checker (.*);

`default_nettype wire
